[rtl/core/floppy_controller_command_engine_core_defines.svh]
// Assertion macros shared by the floppy controller command engine RTL.
// Each macro expects the signals aclk and aresetn in the scope of use.
`ifndef FLOPPY_CONTROLLER_COMMAND_ENGINE_CORE_DEFINES_SVH
`define FLOPPY_CONTROLLER_COMMAND_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FCCE_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fcce: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FCCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fcce: next-cycle check failed");

`endif

[rtl/core/fcce_pkg.sv]
// ----------------------------------------------------------------------------
// fcce_pkg
// Shared constants, codes and control types of the floppy command engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fcce_pkg;

    localparam int REVOLUTION_US = 200000;
    localparam int REV_W         = $clog2(REVOLUTION_US + 1);
    localparam int DIV_CNT_W     = $clog2(REV_W);
    localparam int DELAY_W       = 21;
    localparam int STEP_W        = 14;
    localparam int FMT_W         = 10;
    localparam int ARG_SLOTS     = 5;
    localparam int RES_SLOTS     = 8;

    // Request kinds carried on the input tuser.
    localparam logic [2:0] REQ_STATUS_RD = 3'd0;
    localparam logic [2:0] REQ_DATA_RD   = 3'd1;
    localparam logic [2:0] REQ_DATA_WR   = 3'd2;
    localparam logic [2:0] REQ_OP_WR     = 3'd3;
    localparam logic [2:0] REQ_TICK      = 3'd4;

    // Command opcodes as written to the data register. A format opcode is
    // recognised after masking off its recording mode bit.
    localparam logic [7:0] OP_SPECIFY     = 8'h03;
    localparam logic [7:0] OP_RECAL       = 8'h07;
    localparam logic [7:0] OP_SEEK        = 8'h0F;
    localparam logic [7:0] OP_SENSE       = 8'h08;
    localparam logic [7:0] OP_FORMAT      = 8'h0D;
    localparam logic [7:0] OP_FORMAT_MASK = 8'hBF;

    // Active command codes.
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_INVALID = 3'd1;
    localparam logic [2:0] CMD_SPECIFY = 3'd2;
    localparam logic [2:0] CMD_SENSE   = 3'd3;
    localparam logic [2:0] CMD_RECAL   = 3'd4;
    localparam logic [2:0] CMD_SEEK    = 3'd5;
    localparam logic [2:0] CMD_FORMAT  = 3'd6;

    // Read data source.
    localparam logic [1:0] RD_ZERO   = 2'd0;
    localparam logic [1:0] RD_STATUS = 2'd1;
    localparam logic [1:0] RD_RESULT = 2'd2;

    // Delay counter operations.
    localparam logic [2:0] DL_HOLD  = 3'd0;
    localparam logic [2:0] DL_ZERO  = 3'd1;
    localparam logic [2:0] DL_SHORT = 3'd2;
    localparam logic [2:0] DL_REV   = 3'd3;
    localparam logic [2:0] DL_STEP  = 3'd4;
    localparam logic [2:0] DL_QUOT  = 3'd5;
    localparam logic [2:0] DL_TICK  = 3'd6;

    localparam logic [DELAY_W-1:0] SHORT_DELAY_US = DELAY_W'(12);

    typedef struct packed {
        logic       out_load;
        logic [1:0] rd_sel;
        logic [7:0] stat_byte;
        logic       irq_raise;
        logic       irq_clear;
        logic [2:0] dly_op;
        logic       arg_clear;
        logic       arg_push;
        logic       need_load;
        logic [2:0] need_val;
        logic       fmt_start;
        logic       fmt_inc;
        logic       fmt_clear;
        logic       step_load;
        logic       goal_load;
        logic       goal_from_arg;
        logic       track_move;
        logic       st0_seek;
        logic       st1_overrun;
        logic       res_load;
        logic [2:0] res_cmd;
        logic       res_read;
        logic       res_clear;
        logic       op_load;
        logic       div_start;
    } fcce_cmd_t;

    typedef struct packed {
        logic dly_zero;
        logic args_done;
        logic fmt_done;
        logic res_last;
        logic trk_eq;
        logic div_done;
    } fcce_stat_t;

endpackage

`default_nettype wire

[rtl/core/fcce_datapath.sv]
// ----------------------------------------------------------------------------
// fcce_datapath
// Argument and result stores, track, timing counters and the pacing divider.
// ----------------------------------------------------------------------------
`default_nettype none

module fcce_datapath (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  fcce_pkg::fcce_cmd_t   cmd,
    input  wire  [7:0]            data_in,
    input  wire  [15:0]           elapsed_us,
    output fcce_pkg::fcce_stat_t  stat,
    output logic [7:0]            rd_value,
    output logic                  irq_next
);
    import fcce_pkg::*;

    localparam logic [7:0] ST2_VALUE = 8'h00;

    logic [7:0]           arg_reg [ARG_SLOTS];
    logic [7:0]           res_reg [RES_SLOTS];
    logic [2:0]           arg_cnt_reg, arg_cnt_next;
    logic [2:0]           need_reg, need_next;
    logic [DELAY_W-1:0]   dly_reg, dly_next;
    logic [2:0]           avail_reg, avail_next;
    logic [2:0]           idx_reg, idx_next;
    logic [7:0]           trk_reg, trk_next;
    logic [7:0]           goal_reg, goal_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [7:0]           st0_reg, st0_next;
    logic [7:0]           st1_reg, st1_next;
    logic [7:0]           op_reg, op_next;
    logic [FMT_W-1:0]     fdone_reg, fdone_next;
    logic [FMT_W-1:0]     ftotal_reg, ftotal_next;
    logic                 irq_reg;
    logic [REV_W-1:0]     quot_reg, quot_next;
    logic [FMT_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic                 busy_reg, busy_next;

    logic                 push_ok;
    logic [2:0]           cnt_after;
    logic [FMT_W-1:0]     divisor;
    logic [FMT_W:0]       shifted;
    logic [FMT_W:0]       diff;
    logic                 ge;
    logic                 irq_en;
    logic [4:0]           step_nib;
    logic [DELAY_W-1:0]   us_ext;

    assign push_ok   = arg_cnt_reg < 3'(ARG_SLOTS);
    assign cnt_after = arg_cnt_reg + {2'b00, push_ok};
    assign divisor   = {arg_reg[2], 2'b00};
    assign shifted   = {rem_reg, quot_reg[REV_W-1]};
    assign diff      = shifted - {1'b0, divisor};
    assign ge        = shifted >= {1'b0, divisor};
    assign irq_en    = cmd.op_load ? data_in[3] : op_reg[3];
    assign step_nib  = 5'd16 - {1'b0, arg_reg[0][7:4]};
    assign us_ext    = DELAY_W'(elapsed_us);

    assign stat.dly_zero  = (dly_reg == '0);
    assign stat.args_done = (cnt_after >= need_reg);
    assign stat.fmt_done  = (fdone_reg >= ftotal_reg);
    assign stat.res_last  = ({1'b0, idx_reg} + 4'd1) >= {1'b0, avail_reg};
    assign stat.trk_eq    = (trk_reg == goal_reg);
    assign stat.div_done  = busy_reg && (dcnt_reg == DIV_CNT_W'(REV_W - 1));

    always_comb begin
        case (cmd.rd_sel)
            RD_STATUS: rd_value = cmd.stat_byte;
            RD_RESULT: rd_value = res_reg[idx_reg];
            default:   rd_value = 8'h00;
        endcase
    end

    always_comb begin
        arg_cnt_next = arg_cnt_reg;
        need_next    = need_reg;
        dly_next     = dly_reg;
        avail_next   = avail_reg;
        idx_next     = idx_reg;
        trk_next     = trk_reg;
        goal_next    = goal_reg;
        step_next    = step_reg;
        st0_next     = st0_reg;
        st1_next     = st1_reg;
        op_next      = op_reg;
        fdone_next   = fdone_reg;
        ftotal_next  = ftotal_reg;
        irq_next     = irq_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        dcnt_next    = dcnt_reg;
        busy_next    = busy_reg;

        if (cmd.arg_clear) arg_cnt_next = 3'd0;
        if (cmd.arg_push)  arg_cnt_next = cnt_after;
        if (cmd.need_load) need_next = cmd.need_val;

        case (cmd.dly_op)
            DL_ZERO:  dly_next = '0;
            DL_SHORT: dly_next = SHORT_DELAY_US;
            DL_REV:   dly_next = DELAY_W'(REVOLUTION_US);
            DL_STEP:  dly_next = DELAY_W'(step_reg);
            DL_QUOT:  dly_next = DELAY_W'(quot_reg);
            DL_TICK:  dly_next = (dly_reg > us_ext) ? dly_reg - us_ext : '0;
            default:  dly_next = dly_reg;
        endcase

        if (cmd.track_move) begin
            if (trk_reg > goal_reg) trk_next = trk_reg - 8'd1;
            else if (trk_reg < goal_reg) trk_next = trk_reg + 8'd1;
        end
        if (cmd.goal_load) goal_next = cmd.goal_from_arg ? arg_reg[1] : 8'h00;
        if (cmd.step_load) step_next = STEP_W'(step_nib * 14'd1000);

        if (cmd.st0_seek)    st0_next = {5'b00100, arg_reg[0][2:0]};
        if (cmd.st1_overrun) st1_next = 8'h10;
        if (cmd.res_load) begin
            idx_next = 3'd0;
            case (cmd.res_cmd)
                CMD_SENSE:   avail_next = 3'd2;
                CMD_FORMAT:  avail_next = 3'd7;
                CMD_INVALID: begin
                    avail_next = 3'd1;
                    st0_next   = 8'h80;
                end
                default:     avail_next = avail_reg;
            endcase
        end
        if (cmd.res_read) idx_next = idx_reg + 3'd1;
        if (cmd.res_clear) begin
            idx_next   = 3'd0;
            avail_next = 3'd0;
        end

        if (cmd.op_load) op_next = data_in;

        if (cmd.fmt_start) begin
            fdone_next  = '0;
            ftotal_next = {arg_reg[2], 2'b00};
        end
        if (cmd.fmt_inc && fdone_reg != {FMT_W{1'b1}}) fdone_next = fdone_reg + 1'b1;
        if (cmd.fmt_clear) begin
            fdone_next  = '0;
            ftotal_next = '0;
        end

        if (cmd.irq_clear) irq_next = 1'b0;
        else if (cmd.irq_raise && irq_en) irq_next = 1'b1;

        // Restoring division of the revolution time, one quotient bit a cycle.
        if (cmd.div_start) begin
            quot_next = REV_W'(REVOLUTION_US);
            rem_next  = '0;
            dcnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[FMT_W-1:0] : shifted[FMT_W-1:0];
            quot_next = {quot_reg[REV_W-2:0], ge};
            dcnt_next = dcnt_reg + 1'b1;
            if (stat.div_done) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arg_cnt_reg <= 3'd0;
            need_reg    <= 3'd0;
            dly_reg     <= '0;
            avail_reg   <= 3'd0;
            idx_reg     <= 3'd0;
            trk_reg     <= 8'h00;
            goal_reg    <= 8'h00;
            step_reg    <= STEP_W'(1000);
            st0_reg     <= 8'h00;
            st1_reg     <= 8'h00;
            op_reg      <= 8'h0C;
            fdone_reg   <= '0;
            ftotal_reg  <= '0;
            irq_reg     <= 1'b0;
            dcnt_reg    <= '0;
            busy_reg    <= 1'b0;
        end else begin
            arg_cnt_reg <= arg_cnt_next;
            need_reg    <= need_next;
            dly_reg     <= dly_next;
            avail_reg   <= avail_next;
            idx_reg     <= idx_next;
            trk_reg     <= trk_next;
            goal_reg    <= goal_next;
            step_reg    <= step_next;
            st0_reg     <= st0_next;
            st1_reg     <= st1_next;
            op_reg      <= op_next;
            fdone_reg   <= fdone_next;
            ftotal_reg  <= ftotal_next;
            irq_reg     <= irq_next;
            dcnt_reg    <= dcnt_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (cmd.arg_push && push_ok) arg_reg[arg_cnt_reg] <= data_in;
        if (cmd.res_load) begin
            case (cmd.res_cmd)
                CMD_SENSE: begin
                    res_reg[0] <= st0_reg;
                    res_reg[1] <= trk_reg;
                end
                CMD_FORMAT: begin
                    res_reg[0] <= st0_reg;
                    res_reg[1] <= cmd.st1_overrun ? 8'h10 : st1_reg;
                    res_reg[2] <= ST2_VALUE;
                    res_reg[3] <= trk_reg;
                    res_reg[4] <= 8'h00;
                    res_reg[5] <= 8'h00;
                    res_reg[6] <= arg_reg[4];
                end
                CMD_INVALID: res_reg[0] <= 8'h80;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/fcce_ctrl.sv]
// ----------------------------------------------------------------------------
// fcce_ctrl
// Command phase state machine and item sequencer of the floppy command engine.
// ----------------------------------------------------------------------------
`default_nettype none

`include "floppy_controller_command_engine_core_defines.svh"

module fcce_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   item_fire,
    input  wire  [2:0]            req_type,
    input  wire  [7:0]            data_in,
    input  fcce_pkg::fcce_stat_t  stat,
    output fcce_pkg::fcce_cmd_t   cmd,
    output logic                  seq_idle
);
    import fcce_pkg::*;

    localparam logic [3:0] PH_PRE_OP     = 4'd0;
    localparam logic [3:0] PH_WAIT_OP    = 4'd1;
    localparam logic [3:0] PH_PRE_ARG    = 4'd2;
    localparam logic [3:0] PH_WAIT_ARG   = 4'd3;
    localparam logic [3:0] PH_INTER_ARG  = 4'd4;
    localparam logic [3:0] PH_WAIT_WRITE = 4'd5;
    localparam logic [3:0] PH_EXEC       = 4'd6;
    localparam logic [3:0] PH_RES_WAIT   = 4'd7;
    localparam logic [3:0] PH_RES_INTER  = 4'd8;
    localparam logic [3:0] PH_RESETTING  = 4'd9;

    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_EXEC = 2'd1;
    localparam logic [1:0] SQ_DIV  = 2'd2;

    logic [3:0] phase_reg, phase_next;
    logic [2:0] act_reg, act_next;
    logic [1:0] sq_reg, sq_next;
    logic       do_res;
    logic [2:0] res_sel;
    logic [7:0] stat_byte;
    logic       format_exec;
    logic       act_has_result;

    assign seq_idle = (sq_reg == SQ_IDLE);

    always_comb begin
        case (phase_reg)
            PH_WAIT_OP, PH_WAIT_ARG: stat_byte = 8'h80;
            PH_WAIT_WRITE:           stat_byte = 8'hB0;
            PH_EXEC:                 stat_byte = 8'h30;
            PH_RES_WAIT:             stat_byte = 8'hD0;
            default:                 stat_byte = 8'h00;
        endcase
    end

    always_comb begin
        cmd           = '0;
        cmd.stat_byte = stat_byte;
        phase_next    = phase_reg;
        act_next      = act_reg;
        sq_next       = sq_reg;
        do_res        = 1'b0;
        res_sel       = act_reg;

        case (sq_reg)
            SQ_IDLE: begin
                if (item_fire) begin
                    cmd.out_load = 1'b1;
                    case (req_type)
                        REQ_STATUS_RD: cmd.rd_sel = RD_STATUS;
                        REQ_DATA_RD: begin
                            if (phase_reg == PH_RES_WAIT) begin
                                cmd.rd_sel    = RD_RESULT;
                                cmd.res_read  = 1'b1;
                                cmd.irq_clear = 1'b1;
                                cmd.dly_op    = DL_SHORT;
                                if (stat.res_last) begin
                                    phase_next = PH_PRE_OP;
                                    act_next   = CMD_NONE;
                                end else begin
                                    phase_next = PH_RES_INTER;
                                end
                            end
                        end
                        REQ_DATA_WR: begin
                            case (phase_reg)
                                PH_WAIT_OP: begin
                                    cmd.arg_clear = 1'b1;
                                    cmd.need_load = 1'b1;
                                    cmd.dly_op    = DL_SHORT;
                                    phase_next    = PH_PRE_ARG;
                                    if (data_in == OP_SPECIFY) begin
                                        act_next     = CMD_SPECIFY;
                                        cmd.need_val = 3'd2;
                                    end else if (data_in == OP_RECAL) begin
                                        act_next     = CMD_RECAL;
                                        cmd.need_val = 3'd1;
                                    end else if (data_in == OP_SEEK) begin
                                        act_next     = CMD_SEEK;
                                        cmd.need_val = 3'd2;
                                    end else if (data_in == OP_SENSE) begin
                                        cmd.need_load = 1'b0;
                                        cmd.dly_op    = DL_HOLD;
                                        cmd.irq_clear = 1'b1;
                                        act_next      = CMD_SENSE;
                                        do_res        = 1'b1;
                                        res_sel       = CMD_SENSE;
                                    end else if ((data_in & OP_FORMAT_MASK) == OP_FORMAT) begin
                                        act_next     = CMD_FORMAT;
                                        cmd.need_val = 3'd5;
                                    end else begin
                                        cmd.need_load = 1'b0;
                                        cmd.dly_op    = DL_HOLD;
                                        act_next      = CMD_INVALID;
                                        do_res        = 1'b1;
                                        res_sel       = CMD_INVALID;
                                    end
                                end
                                PH_WAIT_ARG: begin
                                    cmd.arg_push = 1'b1;
                                    phase_next   = PH_INTER_ARG;
                                    if (stat.args_done) begin
                                        cmd.out_load = 1'b0;
                                        sq_next      = SQ_EXEC;
                                    end
                                end
                                PH_WAIT_WRITE: begin
                                    phase_next    = PH_EXEC;
                                    cmd.dly_op    = DL_ZERO;
                                    cmd.irq_clear = 1'b1;
                                    cmd.fmt_inc   = 1'b1;
                                end
                                default: ;
                            endcase
                        end
                        REQ_OP_WR: begin
                            cmd.op_load = 1'b1;
                            if (!data_in[2]) begin
                                cmd.dly_op    = DL_ZERO;
                                cmd.fmt_clear = 1'b1;
                                cmd.res_clear = 1'b1;
                                phase_next    = PH_RESETTING;
                                act_next      = CMD_NONE;
                            end else if (phase_reg == PH_RESETTING) begin
                                phase_next    = PH_WAIT_OP;
                                cmd.irq_raise = 1'b1;
                            end
                        end
                        REQ_TICK: begin
                            if (!stat.dly_zero) begin
                                cmd.dly_op = DL_TICK;
                            end else begin
                                case (phase_reg)
                                    PH_PRE_OP: phase_next = PH_WAIT_OP;
                                    PH_PRE_ARG, PH_INTER_ARG: phase_next = PH_WAIT_ARG;
                                    PH_RES_INTER: phase_next = PH_RES_WAIT;
                                    PH_WAIT_WRITE: begin
                                        cmd.st1_overrun = 1'b1;
                                        do_res          = 1'b1;
                                    end
                                    PH_EXEC: begin
                                        case (act_reg)
                                            CMD_SEEK, CMD_RECAL: begin
                                                if (!stat.trk_eq) begin
                                                    cmd.dly_op     = DL_STEP;
                                                    cmd.track_move = 1'b1;
                                                end else begin
                                                    cmd.dly_op    = DL_SHORT;
                                                    cmd.st0_seek  = 1'b1;
                                                    cmd.irq_raise = 1'b1;
                                                    phase_next    = PH_PRE_OP;
                                                end
                                            end
                                            CMD_FORMAT: begin
                                                if (stat.fmt_done) begin
                                                    do_res = 1'b1;
                                                end else begin
                                                    phase_next    = PH_WAIT_WRITE;
                                                    cmd.dly_op    = DL_QUOT;
                                                    cmd.irq_raise = 1'b1;
                                                end
                                            end
                                            default: do_res = 1'b1;
                                        endcase
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
            end
            SQ_EXEC: begin
                // Last argument byte accepted: start the command.
                cmd.out_load = 1'b1;
                sq_next      = SQ_IDLE;
                case (act_reg)
                    CMD_FORMAT: begin
                        phase_next    = PH_EXEC;
                        cmd.dly_op    = DL_REV;
                        cmd.fmt_start = 1'b1;
                        cmd.div_start = 1'b1;
                        cmd.out_load  = 1'b0;
                        sq_next       = SQ_DIV;
                    end
                    CMD_SPECIFY: begin
                        cmd.step_load = 1'b1;
                        do_res        = 1'b1;
                    end
                    CMD_RECAL: begin
                        phase_next    = PH_EXEC;
                        cmd.goal_load = 1'b1;
                        cmd.dly_op    = DL_ZERO;
                    end
                    CMD_SEEK: begin
                        phase_next        = PH_EXEC;
                        cmd.goal_load     = 1'b1;
                        cmd.goal_from_arg = 1'b1;
                        cmd.dly_op        = DL_ZERO;
                    end
                    default: do_res = 1'b1;
                endcase
            end
            SQ_DIV: begin
                if (stat.div_done) begin
                    cmd.out_load = 1'b1;
                    sq_next      = SQ_IDLE;
                end
            end
            default: sq_next = SQ_IDLE;
        endcase

        if (do_res) begin
            case (res_sel)
                CMD_SENSE, CMD_INVALID, CMD_FORMAT: begin
                    cmd.res_load  = 1'b1;
                    cmd.res_cmd   = res_sel;
                    cmd.irq_raise = cmd.irq_raise || (res_sel == CMD_FORMAT);
                    phase_next    = PH_RES_WAIT;
                end
                default: begin
                    phase_next = PH_PRE_OP;
                    cmd.dly_op = DL_SHORT;
                    act_next   = CMD_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT_OP;
            act_reg   <= CMD_NONE;
            sq_reg    <= SQ_IDLE;
        end else begin
            phase_reg <= phase_next;
            act_reg   <= act_next;
            sq_reg    <= sq_next;
        end
    end

    assign format_exec    = (act_reg == CMD_FORMAT) && (phase_reg == PH_EXEC);
    assign act_has_result = (act_reg == CMD_SENSE) || (act_reg == CMD_FORMAT)
                         || (act_reg == CMD_INVALID);

    `FCCE_ASSERT_IMPLIES(a_div_in_format, sq_reg == SQ_DIV, format_exec)
    `FCCE_ASSERT_IMPLIES(a_write_wait_format, phase_reg == PH_WAIT_WRITE, act_reg == CMD_FORMAT)
    `FCCE_ASSERT_NEXT(a_exec_one_cycle, sq_reg == SQ_EXEC, sq_reg == SQ_IDLE || sq_reg == SQ_DIV)
    `FCCE_ASSERT_IMPLIES(a_result_cmd, phase_reg == PH_RES_WAIT, act_has_result)

endmodule

`default_nettype wire

[rtl/core/floppy_controller_command_engine_core.sv]
// ----------------------------------------------------------------------------
// floppy_controller_command_engine_core
// Floppy disk controller command engine with a stream bus front end.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  s_       in         tuser: request kind; tdata: data byte, elapsed time
//  m_       out        tdata: read byte, interrupt level
//
// Most beats complete while the sequencer is idle. The last argument byte of a
// command completes from the execute step, and that of a format command only
// once the bit-serial divider that works out the format write pacing is done.
// Reset is synchronous on aresetn; no clearing pass.
// A result waits in the output register while m_tready is low; the next
// input beat is taken in the cycle the waiting result is taken.
`default_nettype none

module floppy_controller_command_engine_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // [7:0] data_in, [23:8] elapsed_us
    input  wire  [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata    // [7:0] read_data, [8] irq, rest zero
);
    import fcce_pkg::*;

    fcce_cmd_t  cmd;
    fcce_stat_t stat;
    logic       seq_idle;
    logic       item_fire;
    logic [7:0] rd_value;
    logic       irq_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] rd_reg;
    logic       irq_reg;

    // The output register frees up in the cycle its beat is taken, so an
    // item that completes in its accept cycle never overwrites a result.
    assign s_tready  = seq_idle && (!m_valid_reg || m_tready);
    assign item_fire = s_tvalid && s_tready;

    fcce_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (item_fire),
        .req_type  (s_tuser),
        .data_in   (s_tdata[7:0]),
        .stat      (stat),
        .cmd       (cmd),
        .seq_idle  (seq_idle)
    );

    fcce_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .data_in    (s_tdata[7:0]),
        .elapsed_us (s_tdata[23:8]),
        .stat       (stat),
        .rd_value   (rd_value),
        .irq_next   (irq_next)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload: the read byte and the interrupt level after the item.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            rd_reg  <= rd_value;
            irq_reg <= irq_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0000000, irq_reg, rd_reg};

endmodule

`default_nettype wire
